/* rtl/core/vaw_pkg.sv */
// Package with the item types and the default constants of the vertex attribute welder.
package vaw_pkg;

  localparam int TABLE_DEPTH_DEF     = 256;
  localparam int COMPONENT_WIDTH_DEF = 32;
  localparam logic [31:0] THRESH_RESET = 32'd429497;

  typedef struct packed {
    logic               first_of_mesh;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_w;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vaw_in_t;

  typedef struct packed {
    logic [7:0] pos_index;
    logic       pos_new;
    logic [7:0] norm_index;
    logic       norm_new;
    logic [7:0] uv_index;
    logic       uv_new;
    logic       overflow;
  } vaw_out_t;

  typedef struct packed {
    logic [7:0] idx;
    logic       is_new;
    logic       ovf;
  } vaw_tbl_res_t;

endpackage

/* rtl/core/vertex_attribute_weld.sv */
// Top level of the vertex attribute welder: item capture, three tables, result strobe.
//
//   channel  ports                         handshake
//   input    start, busy, in_item          taken when start is high and busy low
//   result   out_valid, out_item           shown for one cycle, cannot be held off
//   config   cfg_we, cfg_wdata             written when cfg_we is high
//
// An item's time from its accepting edge to the edge that takes its result grows
// with r, where r is the largest number of entries that any of the three tables
// reads before it stops; each table memory delivers one entry per cycle to its
// search pipeline until its search stops.
// The next item can be taken at the same edge that takes the result.
// Reset is synchronous and active low; it empties all tables and restores
// the threshold. Table contents are not cleared, only the fill counts.
// Busy stays high from the accepted item until its result strobe.
module vertex_attribute_weld import vaw_pkg::*; #(
  parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  vaw_in_t     in_item,
  output logic        out_valid,
  output vaw_out_t    out_item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int CW = COMPONENT_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t       state_r, state_nxt;
  logic [31:0]  thresh_r;
  vaw_in_t      item_r;
  logic         go_r;
  logic         out_valid_r, out_valid_nxt;
  vaw_out_t     out_r;
  logic         accept;
  logic         pos_done, norm_done, uv_done, all_done;
  vaw_tbl_res_t pos_res, norm_res, uv_res;

  logic [3:0][CW-1:0] pos_val;
  logic [2:0][CW-1:0] norm_val;
  logic [1:0][CW-1:0] uv_val;

  // Each component keeps its low COMPONENT_WIDTH bits; the table treats the
  // top kept bit as the sign.
  assign pos_val  = {CW'(item_r.pos_w), CW'(item_r.pos_z), CW'(item_r.pos_y),
                     CW'(item_r.pos_x)};
  assign norm_val = {CW'(item_r.norm_z), CW'(item_r.norm_y), CW'(item_r.norm_x)};
  assign uv_val   = {CW'(item_r.tex_v), CW'(item_r.tex_u)};

  assign accept   = start && (state_r == S_IDLE);
  // The done flags may still stand from the previous item while go_r is high, as
  // the tables leave T_DONE only on go; all_done masks them with !go_r.
  assign all_done = pos_done && norm_done && uv_done && !go_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (all_done) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thresh_r    <= THRESH_RESET;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= accept;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (out_valid_nxt) begin
      out_r <= '{pos_index: pos_res.idx, pos_new: pos_res.is_new,
                 norm_index: norm_res.idx, norm_new: norm_res.is_new,
                 uv_index: uv_res.idx, uv_new: uv_res.is_new,
                 overflow: pos_res.ovf | norm_res.ovf | uv_res.ovf};
    end
  end

  vaw_table #(.DEPTH(TABLE_DEPTH), .CW(CW), .NCOLS(4)) u_pos (
    .clk(clk), .rst_n(rst_n), .go(go_r), .clear(item_r.first_of_mesh),
    .val(pos_val), .thresh(thresh_r), .done(pos_done), .res(pos_res)
  );

  vaw_table #(.DEPTH(TABLE_DEPTH), .CW(CW), .NCOLS(3)) u_norm (
    .clk(clk), .rst_n(rst_n), .go(go_r), .clear(item_r.first_of_mesh),
    .val(norm_val), .thresh(thresh_r), .done(norm_done), .res(norm_res)
  );

  vaw_table #(.DEPTH(TABLE_DEPTH), .CW(CW), .NCOLS(2)) u_uv (
    .clk(clk), .rst_n(rst_n), .go(go_r), .clear(item_r.first_of_mesh),
    .val(uv_val), .thresh(thresh_r), .done(uv_done), .res(uv_res)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* rtl/core/vaw_table.sv */
// One attribute table: storage memory, pipelined linear search and append.
module vaw_table import vaw_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int CW    = COMPONENT_WIDTH_DEF,
  parameter int NCOLS = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic                      clear,
  input  logic [NCOLS-1:0][CW-1:0]  val,
  input  logic [31:0]               thresh,
  output logic                      done,
  output vaw_tbl_res_t              res
);

  localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW  = $clog2(DEPTH + 1);
  localparam int SW  = 2 * CW + 2;
  localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_SCAN = 3'b010,
    T_DONE = 3'b100
  } tstate_t;

  tstate_t state_r, state_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] issue_r, issue_nxt;
  logic          p1_v_r, p2_v_r;
  logic [IW-1:0] p1_tag_r, p2_tag_r;
  logic          found_r, found_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  vaw_tbl_res_t  res_r, res_nxt;

  logic [NCOLS*CW-1:0] mem [DEPTH];
  logic [NCOLS*CW-1:0] rd_q;
  logic                rd_en, wr_en;
  logic [2*CW-1:0]     sq_r [NCOLS];
  logic [SW-1:0]       sum;
  logic                match_now, finish;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[n_r[IW-1:0]] <= val;
    end
    if (rd_en) begin
      rd_q <= mem[issue_r[IW-1:0]];
    end
  end

  // Stage two: component differences and their squares.
  always_ff @(posedge clk) begin
    for (int c = 0; c < NCOLS; c++) begin
      logic signed [CW:0] dv;
      logic [CW:0]        mg;
      dv = $signed({val[c][CW-1], val[c]}) -
           $signed({rd_q[c*CW+CW-1], rd_q[c*CW +: CW]});
      mg = dv[CW] ? (CW+1)'(-dv) : dv;
      sq_r[c] <= mg[CW-1:0] * mg[CW-1:0];
    end
  end

  // Sum of squares never exceeds SW bits; the threshold is below 2^32, so
  // comparing the full sum equals comparing the saturated one.
  always_comb begin
    sum = '0;
    for (int c = 0; c < NCOLS; c++) begin
      sum = sum + SW'(sq_r[c]);
    end
  end

  assign match_now = p2_v_r && !found_r && (sum < SW'(thresh));
  assign rd_en     = (state_r == T_SCAN) && (issue_r < n_r) && !found_r && !match_now;
  assign finish    = (state_r == T_SCAN) &&
                     (found_r || ((issue_r >= n_r) && !p1_v_r && !p2_v_r));
  assign wr_en     = finish && !found_r && (n_r < DEPTH_N);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    n_nxt     = n_r;
    issue_nxt = issue_r;
    found_nxt = found_r;
    fidx_nxt  = fidx_r;
    res_nxt   = res_r;
    if (match_now) begin
      found_nxt = 1'b1;
      fidx_nxt  = p2_tag_r;
    end
    if (rd_en) begin
      issue_nxt = issue_r + 1'b1;
    end
    case (state_r)
      T_IDLE, T_DONE: begin
        if (go) begin
          state_nxt = T_SCAN;
          n_nxt     = clear ? '0 : count_r;
          count_nxt = clear ? '0 : count_r;
          issue_nxt = '0;
          found_nxt = 1'b0;
        end
      end
      T_SCAN: begin
        if (finish) begin
          state_nxt = T_DONE;
          if (found_r) begin
            res_nxt = '{idx: 8'(fidx_r), is_new: 1'b0, ovf: 1'b0};
          end else if (n_r >= DEPTH_N) begin
            res_nxt = '{idx: 8'd0, is_new: 1'b0, ovf: 1'b1};
          end else begin
            res_nxt   = '{idx: 8'(n_r), is_new: 1'b1, ovf: 1'b0};
            count_nxt = n_r + 1'b1;
          end
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      count_r <= '0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      p1_v_r  <= rd_en;
      p2_v_r  <= p1_v_r;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    issue_r  <= issue_nxt;
    fidx_r   <= fidx_nxt;
    res_r    <= res_nxt;
    p1_tag_r <= issue_r[IW-1:0];
    p2_tag_r <= p1_tag_r;
  end

  assign done = (state_r == T_DONE);
  assign res  = res_r;

endmodule
